/* rtl/hcrc8_rx_pkg.sv */
// Shared constants and types of the header-framed CRC-8 byte receiver.
package hcrc8_rx_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned POS_W = 3;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
	localparam logic [POS_W-1:0] PAYLOAD_BYTES = 3'd4;

	// One byte handed from the input stage to the frame tracker.
	typedef struct packed {
		logic take;
		logic [BYTE_W-1:0] data;
	} hcrc8_rx_beat_t;

	// Fields of one finished frame.
	typedef struct packed {
		logic [WORD_W-1:0] payload_word;
		logic [BYTE_W-1:0] received_check;
		logic [BYTE_W-1:0] computed_check;
		logic check_ok;
	} hcrc8_rx_result_t;

	// What the frame tracker reports about the byte now in the input stage.
	typedef struct packed {
		logic is_check;
		hcrc8_rx_result_t result;
	} hcrc8_rx_status_t;

endpackage

/* rtl/header_crc8_frame_receiver.sv */
// Top level of the header-framed byte receiver with CRC-8 check.
//
// Received bytes arrive one beat at a time on the input channel (in_valid,
// in_stall, rx_byte). While hunting, bytes are dropped until one equals the
// header register. The next four bytes form the payload, least significant
// byte first, and the fifth is the transmitted CRC-8. A header value inside
// a frame is ordinary data. After the check byte one result beat leaves on
// the output channel (out_valid, out_stall and the four result fields),
// carrying the payload, both CRC values and a match flag; a failed check is
// still reported, with check_ok low.
// One byte per cycle unless a check byte stalls: the input register feeds
// the frame tracker, whose CRC step is eight unrolled xor-shift stages, and
// the result register holds a frame the cycle after its check byte is taken.
// A result waiting in the output register does not block payload bytes of
// the next frame; only a second check byte waits for the register to empty.
// Asynchronous reset (arst_n low) empties both stages, returns the tracker to
// header hunt and loads the header register with 0xAA. The user must write
// it via cfg_wr_en/cfg_wr_data only while no frame is open (not enforced).
module header_crc8_frame_receiver
	import hcrc8_rx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [BYTE_W-1:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic [WORD_W-1:0] payload_word,
	output logic [BYTE_W-1:0] received_check,
	output logic [BYTE_W-1:0] computed_check,
	output logic check_ok
);

	logic [BYTE_W-1:0] header_q;
	logic valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	logic go_s1;
	logic out_valid_q;
	hcrc8_rx_result_t result_q;
	hcrc8_rx_beat_t beat;
	hcrc8_rx_status_t status;

	// Header register; user must write only while receiver is idle; not checked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_wr_en) begin
			header_q <= cfg_wr_data;
		end
	end

	// The byte in the input stage moves on unless it is a check byte and the
	// result register still holds a frame that the consumer has not taken.
	assign go_s1 = !status.is_check || !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !go_s1;

	assign beat.take = valid_s1 && go_s1;
	assign beat.data = rx_byte_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	hcrc8_rx_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.header_value(header_q),
		.beat(beat),
		.status(status)
	);

	// Result register: loads on a check byte, empties when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (beat.take && status.is_check) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat.take && status.is_check) begin
			result_q <= status.result;
		end
	end

	assign out_valid = out_valid_q;
	assign payload_word = result_q.payload_word;
	assign received_check = result_q.received_check;
	assign computed_check = result_q.computed_check;
	assign check_ok = result_q.check_ok;

`ifndef SYNTHESIS
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled without a blocked check byte");

	a_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> check_ok == (received_check == computed_check))
		else $error("check_ok disagrees with the two CRC values");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		beat.take && status.is_check |=> out_valid_q)
		else $error("check byte taken but no result beat presented");
`endif

endmodule

/* rtl/hcrc8_rx_crc.sv */
// CRC-8 update over one byte, polynomial 0x31, MSB first.
module hcrc8_rx_crc
	import hcrc8_rx_pkg::*;
(
	input  logic [BYTE_W-1:0] crc,
	input  logic [BYTE_W-1:0] data,
	output logic [BYTE_W-1:0] crc_next
);

	always_comb begin
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

/* rtl/hcrc8_rx_frame.sv */
// Frame tracker: header hunt, payload collection and running CRC.
module hcrc8_rx_frame
	import hcrc8_rx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [BYTE_W-1:0] header_value,
	input  hcrc8_rx_beat_t beat,
	output hcrc8_rx_status_t status
);

	logic in_frame_q;
	logic [POS_W-1:0] byte_pos_q;
	logic [WORD_W-1:0] payload_q;
	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] crc_next;

	hcrc8_rx_crc u_crc (
		.crc(crc_q),
		.data(beat.data),
		.crc_next(crc_next)
	);

	// Any position of four or more treats the byte as the check byte.
	always_comb begin
		status.is_check = in_frame_q && (byte_pos_q >= PAYLOAD_BYTES);
		status.result.payload_word = payload_q;
		status.result.received_check = beat.data;
		status.result.computed_check = crc_q;
		status.result.check_ok = (beat.data == crc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			byte_pos_q <= '0;
			payload_q <= '0;
			crc_q <= CRC_INIT;
		end else if (beat.take) begin
			if (!in_frame_q) begin
				if (beat.data == header_value) begin
					in_frame_q <= 1'b1;
					byte_pos_q <= '0;
					payload_q <= '0;
					crc_q <= CRC_INIT;
				end
			end else if (byte_pos_q < PAYLOAD_BYTES) begin
				payload_q <= {beat.data, payload_q[WORD_W-1:BYTE_W]};
				crc_q <= crc_next;
				byte_pos_q <= byte_pos_q + 1'b1;
			end else begin
				in_frame_q <= 1'b0;
				byte_pos_q <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= PAYLOAD_BYTES)
		else $error("frame byte position ran past the check byte");

	a_idle_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> byte_pos_q == '0)
		else $error("byte position not cleared while hunting for a header");

	a_check_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		beat.take && status.is_check |=> !in_frame_q)
		else $error("frame not closed after its check byte");
`endif

endmodule

/* tb/sv/hcrc8_rx_tb_pkg.sv */
// Frame predictor and result checker used by the CRC-8 frame receiver testbench.
package hcrc8_rx_tb_pkg;
	import hcrc8_rx_pkg::*;

	class crc_frame_tracker;
		logic [BYTE_W-1:0] header;
		logic framing;
		logic [POS_W-1:0] taken;
		logic [WORD_W-1:0] payload;
		logic [BYTE_W-1:0] crc;
		hcrc8_rx_result_t frames_due[$];
		int frames_checked;
		int bad_crc_frames;
		int fault_count;

		function new();
			header = HEADER_RESET;
			framing = 1'b0;
			taken = '0;
			payload = '0;
			crc = CRC_INIT;
			frames_checked = 0;
			bad_crc_frames = 0;
			fault_count = 0;
		endfunction

		// One byte of CRC-8, MSB first, no reflection.
		static function logic [BYTE_W-1:0] crc8_step(logic [BYTE_W-1:0] c,
				logic [BYTE_W-1:0] b);
			logic [BYTE_W-1:0] r;
			r = c ^ b;
			for (int k = 0; k < BYTE_W; k++)
				r = r[BYTE_W-1] ? ({r[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {r[BYTE_W-2:0], 1'b0};
			return r;
		endfunction

		// Called for every accepted input beat.
		function void take_byte(logic [BYTE_W-1:0] b);
			hcrc8_rx_result_t due;
			if (!framing) begin
				if (b == header) begin
					framing = 1'b1;
					taken = '0;
					payload = '0;
					crc = CRC_INIT;
				end
			end else if (taken < PAYLOAD_BYTES) begin
				payload = {b, payload[WORD_W-1:BYTE_W]};
				crc = crc8_step(crc, b);
				taken = taken + 1'b1;
			end else begin
				due.payload_word = payload;
				due.received_check = b;
				due.computed_check = crc;
				due.check_ok = (b == crc);
				frames_due.push_back(due);
				if (!due.check_ok)
					bad_crc_frames++;
				framing = 1'b0;
				taken = '0;
			end
		endfunction

		function void fault(string what, hcrc8_rx_result_t want, hcrc8_rx_result_t got);
			fault_count++;
			if (fault_count <= 10)
				$display("%0t %s: expected payload %h rx %h crc %h ok %b, got payload %h rx %h crc %h ok %b",
					$time, what, want.payload_word, want.received_check, want.computed_check,
					want.check_ok, got.payload_word, got.received_check, got.computed_check,
					got.check_ok);
		endfunction

		// Called for every accepted output beat.
		function void match_frame(hcrc8_rx_result_t got);
			hcrc8_rx_result_t want;
			if (frames_due.size() == 0) begin
				fault("result with no frame pending", '0, got);
				return;
			end
			want = frames_due.pop_front();
			frames_checked++;
			if (got.payload_word !== want.payload_word ||
					got.received_check !== want.received_check ||
					got.computed_check !== want.computed_check ||
					got.check_ok !== want.check_ok)
				fault("frame mismatch", want, got);
		endfunction
	endclass

endpackage

/* tb/sv/header_crc8_frame_receiver_tb.sv */
// Self-checking testbench of the header-framed CRC-8 byte receiver.
module header_crc8_frame_receiver_tb;
	import hcrc8_rx_pkg::*;
	import hcrc8_rx_tb_pkg::*;

	// Number of random frames run under each header setting.
	localparam int FRAMES_PER_SETTING = 27;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [BYTE_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [WORD_W-1:0] payload_word;
	logic [BYTE_W-1:0] received_check;
	logic [BYTE_W-1:0] computed_check;
	logic check_ok;

	crc_frame_tracker tracker = new();

	// When set, neither side inserts idle cycles, so the block sees
	// back-to-back beats on both channels.
	bit quiet = 1'b0;
	int bytes_sent = 0;
	int settings_used = 1;

	header_crc8_frame_receiver u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_word(payload_word),
		.received_check(received_check),
		.computed_check(computed_check),
		.check_ok(check_ok)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sends one byte as an input beat. Every task here starts and ends on a
	// falling edge; the beat counts as taken at the first rising edge with
	// in_stall low. When no gap is drawn, in_valid simply stays high and the
	// new byte replaces the old one, so valid is never dropped and raised
	// within the same time step.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		bit accepted;
		gap = quiet ? 0 : $urandom_range(6, 0);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do begin
			@(posedge clk);
			accepted = !in_stall;
			if (accepted)
				tracker.take_byte(b);
			@(negedge clk);
		end while (!accepted);
		bytes_sent++;
	endtask

	// A complete frame under the current header. The payload word is sent
	// least significant byte first. A bad frame gets a check byte that is
	// guaranteed to differ from the true CRC.
	task automatic send_frame(input logic [WORD_W-1:0] word, input bit good);
		logic [BYTE_W-1:0] crc;
		crc = CRC_INIT;
		send_byte(tracker.header);
		for (int i = 0; i < 4; i++) begin
			crc = crc_frame_tracker::crc8_step(crc, word[i*BYTE_W +: BYTE_W]);
			send_byte(word[i*BYTE_W +: BYTE_W]);
		end
		send_byte(good ? crc : (crc ^ BYTE_W'($urandom_range(255, 1))));
	endtask

	// The sender holds off until every frame it has completed has come
	// out of the block.
	task automatic hold_until_drained();
		in_valid = 1'b0;
		while (tracker.frames_due.size() != 0)
			@(negedge clk);
	endtask

	// Brings the block to rest: an open frame is finished with filler
	// bytes, all results are collected, and then a pause lets any ignored
	// bytes still in the pipeline drain out.
	task automatic settle();
		while (tracker.framing)
			send_byte(BYTE_W'($urandom_range(255, 0)));
		hold_until_drained();
		repeat (8) @(negedge clk);
	endtask

	task automatic write_header(input logic [BYTE_W-1:0] v);
		settle();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		tracker.header = v;
		settings_used++;
	endtask

	// Payload bytes lean toward the extremes and the header value, which
	// must be treated as plain data inside a frame.
	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(7, 0))
			0: return 8'h00;
			1: return 8'hFF;
			2: return tracker.header;
			default: return BYTE_W'($urandom_range(255, 0));
		endcase
	endfunction

	// Mostly well-formed frames with random content. Between them sits
	// line noise, and now and then a frame is cut short so the next header
	// lands inside it and the framing slips.
	task automatic run_frames(input int count);
		for (int f = 0; f < count; f++) begin
			if ($urandom_range(7, 0) == 0)
				quiet = !quiet;
			if ($urandom_range(3, 0) == 0)
				repeat ($urandom_range(3, 1)) send_byte(BYTE_W'($urandom_range(255, 0)));
			if ($urandom_range(11, 0) == 0) begin
				send_byte(tracker.header);
				repeat ($urandom_range(3, 0)) send_byte(pick_byte());
			end
			send_frame({pick_byte(), pick_byte(), pick_byte(), pick_byte()},
				$urandom_range(3, 0) != 0);
			if ($urandom_range(24, 0) == 0)
				hold_until_drained();
		end
	endtask

	// Output side: the stall is drawn afresh after every result beat and
	// counted down on falling edges. Results are sampled on the rising edge.
	initial begin : result_sink
		int stall_left;
		hcrc8_rx_result_t got;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.payload_word = payload_word;
				got.received_check = received_check;
				got.computed_check = computed_check;
				got.check_ok = check_ok;
				tracker.match_frame(got);
				stall_left = quiet ? 0 : $urandom_range(6, 0);
			end
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	initial begin : stimulus
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part under the reset header 0xAA. Bytes that are not the
		// header are dropped while hunting; then a frame whose payload holds
		// the header value itself, one with all ones and a wrong check byte,
		// and one with all zeros.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_frame(32'hAA_FF_00_AA, 1'b1);
		send_frame(32'hFF_FF_FF_FF, 1'b0);
		send_frame(32'h00_00_00_00, 1'b1);

		// Random part, walked through the header extremes, two random
		// settings and finally back to the reset value.
		write_header(8'h00);
		run_frames(FRAMES_PER_SETTING);
		write_header(8'hFF);
		run_frames(FRAMES_PER_SETTING);
		repeat (2) begin
			write_header(BYTE_W'($urandom_range(254, 1)));
			run_frames(FRAMES_PER_SETTING);
		end
		write_header(HEADER_RESET);
		run_frames(FRAMES_PER_SETTING);
		settle();

		if (tracker.frames_due.size() != 0)
			tracker.fault("frame never delivered", tracker.frames_due[0], '0);
		$display("Sent %0d bytes under %0d header settings; %0d frames compared, %0d with a bad CRC.",
			bytes_sent, settings_used, tracker.frames_checked, tracker.bad_crc_frames);
		$display("Mismatches: %0d.", tracker.fault_count);
		if (tracker.fault_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this.
	initial begin : watchdog
		#2000000;
		$display("Timeout with %0d frames outstanding.", tracker.frames_due.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
